>>> hdl/sldf_pkg.sv
`default_nettype none
package sldf_pkg;

  localparam int unsigned CfgAddrWidth = 1;
  localparam int unsigned CfgDataWidth = 20;
  localparam int unsigned OutDataWidth = 56;

  localparam logic [CfgAddrWidth-1:0] CFG_TIMEOUT_TICKS = 1'b0;
  localparam logic [CfgAddrWidth-1:0] CFG_MAX_PAYLOAD   = 1'b1;

  localparam logic [19:0] TIMEOUT_RESET     = 20'd1000;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [20:0] ELAPSED_MAX = 21'h1FFFFF;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [2:0] ST_OK               = 3'd0;
  localparam logic [2:0] ST_SYNC_TIMEOUT     = 3'd1;
  localparam logic [2:0] ST_HEADER_TIMEOUT   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG         = 3'd3;
  localparam logic [2:0] ST_PAYLOAD_TIMEOUT  = 3'd4;
  localparam logic [2:0] ST_CHECKSUM_TIMEOUT = 3'd5;
  localparam logic [2:0] ST_BAD_CHECKSUM     = 3'd6;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  command;
    logic [15:0] length;
    logic [2:0]  status;
    logic        last;
  } sldf_result_t;

endpackage
`default_nettype wire

>>> hdl/sldf_core.sv
`default_nettype none
module sldf_core
  import sldf_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    in_mode,
  input  wire  [7:0]             in_byte,
  input  wire                    cfg_we,
  input  wire  [CfgAddrWidth-1:0] cfg_addr,
  input  wire  [CfgDataWidth-1:0] cfg_data,
  input  wire                    res_space,
  output logic                   res_push,
  output sldf_result_t           res
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LENLO = 3'd3,
    PH_LENHI = 3'd4,
    PH_DATA  = 3'd5,
    PH_CSUM  = 3'd6
  } phase_t;

  // input register
  logic       hold_valid;
  logic       hold_mode;
  logic [7:0] hold_byte;

  logic [19:0] timeout_ticks;
  logic [15:0] max_payload;

  phase_t      phase, phase_next;
  logic [7:0]  held_command, held_command_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [20:0] elapsed_ticks, elapsed_ticks_next;

  logic        consume;
  logic        close;
  logic [2:0]  close_status;
  logic [15:0] close_length;
  logic [20:0] elapsed_inc;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign consume  = hold_valid && res_space;
  assign in_ready = !hold_valid || consume;

  always_comb begin
    phase_next         = phase;
    held_command_next  = held_command;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    elapsed_ticks_next = elapsed_ticks;
    close              = 1'b0;
    close_status       = ST_OK;
    close_length       = held_length;
    res_push           = 1'b0;
    res                = '0;
    elapsed_inc        = (elapsed_ticks != ELAPSED_MAX) ? elapsed_ticks + 21'd1 : elapsed_ticks;
    len_full           = {hold_byte, held_length[7:0]};
    count_inc          = payload_count + 16'd1;

    if (consume) begin
      if (hold_mode == MODE_TICK) begin
        elapsed_ticks_next = elapsed_inc;
        if (elapsed_inc > {1'b0, timeout_ticks}) begin
          close = 1'b1;
          case (phase)
            PH_CMD, PH_LENLO, PH_LENHI: close_status = ST_HEADER_TIMEOUT;
            PH_DATA:                    close_status = ST_PAYLOAD_TIMEOUT;
            PH_CSUM:                    close_status = ST_CHECKSUM_TIMEOUT;
            default:                    close_status = ST_SYNC_TIMEOUT;
          endcase
        end
      end else begin
        case (phase)
          PH_SYNC2: begin
            phase_next = (hold_byte == SYNC_SECOND) ? PH_CMD : PH_HUNT;
          end
          PH_CMD: begin
            held_command_next = hold_byte;
            running_xor_next  = hold_byte;
            phase_next        = PH_LENLO;
          end
          PH_LENLO: begin
            held_length_next = {8'd0, hold_byte};
            running_xor_next = running_xor ^ hold_byte;
            phase_next       = PH_LENHI;
          end
          PH_LENHI: begin
            held_length_next = len_full;
            running_xor_next = running_xor ^ hold_byte;
            if (len_full > max_payload) begin
              close        = 1'b1;
              close_status = ST_TOO_LONG;
              close_length = len_full;
            end else begin
              phase_next = (len_full == 16'd0) ? PH_CSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            running_xor_next   = running_xor ^ hold_byte;
            payload_count_next = count_inc;
            if (count_inc >= held_length) begin
              phase_next = PH_CSUM;
            end
            res_push         = 1'b1;
            res.payload_byte = hold_byte;
            res.byte_index   = payload_count;
            res.command      = held_command;
            res.length       = held_length;
            res.status       = ST_OK;
            res.last         = 1'b0;
          end
          PH_CSUM: begin
            close        = 1'b1;
            close_status = (running_xor == hold_byte) ? ST_OK : ST_BAD_CHECKSUM;
          end
          default: begin
            // unused phase code behaves as the hunt
            phase_next = (hold_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
          end
        endcase
      end

      if (close) begin
        res_push           = 1'b1;
        res.payload_byte   = 8'd0;
        res.byte_index     = payload_count;
        res.command        = held_command;
        res.length         = close_length;
        res.status         = close_status;
        res.last           = 1'b1;
        phase_next         = PH_HUNT;
        held_command_next  = 8'd0;
        held_length_next   = 16'd0;
        payload_count_next = 16'd0;
        running_xor_next   = 8'd0;
        elapsed_ticks_next = 21'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
      max_payload   <= MAX_PAYLOAD_RESET;
      phase         <= PH_HUNT;
      held_command  <= 8'd0;
      held_length   <= 16'd0;
      payload_count <= 16'd0;
      running_xor   <= 8'd0;
      elapsed_ticks <= 21'd0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          CFG_MAX_PAYLOAD:   max_payload   <= cfg_data[15:0];
          default: ;
        endcase
      end
      phase         <= phase_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_mode <= in_mode;
      hold_byte <= in_byte;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sldf_out.sv
`default_nettype none
module sldf_out
  import sldf_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  sldf_result_t            push_res,
  output logic                    space,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [OutDataWidth-1:0] m_tdata,
  output logic                    m_tlast
);

  logic         main_valid;
  logic         skid_valid;
  sldf_result_t main_res;
  sldf_result_t skid_res;
  logic         pop;

  assign space    = !skid_valid;
  assign pop      = main_valid && m_tready;
  assign m_tvalid = main_valid;
  assign m_tlast  = main_res.last;
  assign m_tdata  = {5'd0, main_res.status, main_res.length, main_res.command,
                     main_res.byte_index, main_res.payload_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (push) begin
          main_valid <= 1'b1;
        end else if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          main_valid <= 1'b0;
        end
      end else if (push) begin
        if (main_valid) begin
          skid_valid <= 1'b1;
        end else begin
          main_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push) begin
        main_res <= push_res;
      end else if (skid_valid) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_res <= push_res;
      end else begin
        main_res <= push_res;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/sync_length_xor_packet_deframer_top.sv
// a request is held in the input register, and its result is registered in the output buffer before m_tvalid offers it
// throughput: one request per cycle while the output buffer has space; every byte or tick is one state step
// the input register and a two-entry output buffer keep the stream moving under stalls
// reset (rst, synchronous, active high): hunt for sync, all packet state cleared,
// timeout_ticks = 1000, max_payload = 256, no result pending
`default_nettype none
module sync_length_xor_packet_deframer_top
  import sldf_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire  [7:0]              s_tdata,   // rx_byte[7:0]
  input  wire  [0:0]              s_tuser,   // mode[0]
  output logic                    m_tvalid,
  input  wire                     m_tready,
  // payload_byte[7:0], byte_index[23:8], command[31:24], length[47:32],
  // status[50:48], zero[55:51]
  output logic [OutDataWidth-1:0] m_tdata,
  output logic                    m_tlast,   // last
  input  wire                     cfg_we,
  input  wire  [CfgAddrWidth-1:0] cfg_addr,
  input  wire  [CfgDataWidth-1:0] cfg_data
);

  logic         res_space;
  logic         res_push;
  sldf_result_t res;

  sldf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser[0]),
    .in_byte   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res)
  );

  sldf_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_res (res),
    .space    (res_space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res_space)
    else $error("result pushed into a full output buffer");

  a_status_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[7:0] == 8'd0))
    else $error("status result carries a payload byte");

  a_payload_ok_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[50:48] == ST_OK))
    else $error("payload result carries an error status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

endmodule
`default_nettype wire
